// ===== src/button_repeat_menu_navigator_macros.svh =====
// Assertion macros for the button repeat menu navigator.
// Bodies are empty in synthesis builds.
`ifndef BUTTON_REPEAT_MENU_NAVIGATOR_MACROS_SVH
`define BUTTON_REPEAT_MENU_NAVIGATOR_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define BRMN_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define BRMN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define BRMN_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BRMN_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/brmn_pkg.sv =====
package brmn_pkg;

	localparam int PAGE_COUNT   = 4;
	localparam int BUTTON_COUNT = 3;
	// page register is at least as wide as the two-bit page field
	localparam int PAGE_W = (PAGE_COUNT > 4) ? $clog2(PAGE_COUNT) : 2;

	localparam int CNT_W = 16;

	// output queue, depth must be a power of two
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);
	localparam int MAX_RESULTS = BUTTON_COUNT;

	localparam logic [1:0] KEY_LEFT   = 2'd0;
	localparam logic [1:0] KEY_MIDDLE = 2'd1;
	localparam logic [1:0] KEY_RIGHT  = 2'd2;

	localparam logic EV_PRESS = 1'b0;
	localparam logic EV_HOLD  = 1'b1;

	localparam logic [15:0] RST_DEBOUNCE   = 16'd5;
	localparam logic [15:0] RST_FIRST_HOLD = 16'd350;
	localparam logic [15:0] RST_REPEAT_GAP = 16'd120;

	typedef enum logic [1:0] {
		REG_DEBOUNCE   = 2'd0,
		REG_FIRST_HOLD = 2'd1,
		REG_REPEAT_GAP = 2'd2
	} reg_idx_t;

	typedef enum logic [1:0] {
		ACT_CHANGE = 2'd0,
		ACT_INC    = 2'd1,
		ACT_DEC    = 2'd2,
		ACT_NONE   = 2'd3
	} action_t;

	typedef struct packed {
		logic [CNT_W-1:0] debounce_ticks;
		logic [CNT_W-1:0] first_hold;
		logic [CNT_W-1:0] repeat_gap;
	} cfg_t;

	typedef struct packed {
		logic fire;
		logic kind;
	} lane_evt_t;

	typedef struct packed {
		logic [1:0] button_id;
		logic       event_kind;
		action_t    action;
		logic [1:0] page;
		logic       selected;
		logic       redraw;
		logic       last_of_tick;
	} res_t;

endpackage

// ===== src/brmn_lane.sv =====
`include "button_repeat_menu_navigator_macros.svh"

module brmn_lane
	import brmn_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      down,
	input  cfg_t      cfg,
	output lane_evt_t evt
);

	logic [CNT_W-1:0] press_cnt_q, press_cnt_d;
	logic [CNT_W-1:0] hold_cnt_q, hold_cnt_d;
	logic             reported_q, reported_d;
	logic [CNT_W-1:0] press_inc;
	logic [CNT_W-1:0] hold_dec;

	always_comb begin
		press_inc  = (press_cnt_q == '1) ? press_cnt_q : press_cnt_q + CNT_W'(1);
		hold_dec   = hold_cnt_q - CNT_W'(1);
		press_cnt_d = press_cnt_q;
		hold_cnt_d  = hold_cnt_q;
		reported_d  = reported_q;
		evt         = '0;
		if (!down) begin
			press_cnt_d = '0;
			hold_cnt_d  = '0;
			reported_d  = 1'b0;
		end else if (!reported_q) begin
			press_cnt_d = press_inc;
			if (press_inc >= cfg.debounce_ticks) begin
				evt.fire   = 1'b1;
				evt.kind   = EV_PRESS;
				reported_d = 1'b1;
				hold_cnt_d = cfg.first_hold;
			end
		end else begin
			// down-counter wraps when the reload value is zero
			if (hold_dec == '0) begin
				evt.fire   = 1'b1;
				evt.kind   = EV_HOLD;
				hold_cnt_d = cfg.repeat_gap;
			end else begin
				hold_cnt_d = hold_dec;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_cnt_q <= '0;
			hold_cnt_q  <= '0;
			reported_q  <= 1'b0;
		end else if (en) begin
			press_cnt_q <= press_cnt_d;
			hold_cnt_q  <= hold_cnt_d;
			reported_q  <= reported_d;
		end
	end

	`BRMN_ASSERT_IMPL(a_reported_cnt, clk, arst_n, reported_q, press_cnt_q != '0)

endmodule

// ===== src/brmn_merge.sv =====
`include "button_repeat_menu_navigator_macros.svh"

module brmn_merge
	import brmn_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  lane_evt_t evt [BUTTON_COUNT],
	output res_t      res [BUTTON_COUNT]
);

	logic [PAGE_W-1:0] page_q, page_d;
	logic              sel_q, sel_d;

	// apply the lane events in button order; each result sees the menu after its event
	always_comb begin
		logic    later;
		action_t act;
		logic    rd;
		page_d = page_q;
		sel_d  = sel_q;
		for (int b = 0; b < BUTTON_COUNT; b++) begin
			act = ACT_CHANGE;
			rd  = 1'b1;
			if (evt[b].fire) begin
				if (evt[b].kind == EV_PRESS) begin
					if (sel_d) begin
						if (2'(b) == KEY_RIGHT)
							act = ACT_INC;
						else if (2'(b) == KEY_LEFT)
							act = ACT_DEC;
					end else if (2'(b) == KEY_RIGHT) begin
						page_d = (page_d == PAGE_W'(PAGE_COUNT - 1)) ? '0 : page_d + PAGE_W'(1);
					end else if (2'(b) == KEY_LEFT) begin
						page_d = (page_d == '0) ? PAGE_W'(PAGE_COUNT - 1) : page_d - PAGE_W'(1);
					end
					if (2'(b) == KEY_MIDDLE)
						sel_d = !sel_d;
				end else begin
					act = ACT_NONE;
					rd  = 1'b0;
					if (sel_d && 2'(b) != KEY_MIDDLE) begin
						act = (2'(b) == KEY_RIGHT) ? ACT_INC : ACT_DEC;
						rd  = 1'b1;
					end
				end
			end
			later = 1'b0;
			for (int k = b + 1; k < BUTTON_COUNT; k++)
				later = later | evt[k].fire;
			res[b].button_id    = 2'(b);
			res[b].event_kind   = evt[b].kind;
			res[b].action       = act;
			res[b].page         = page_d[1:0];
			res[b].selected     = sel_d;
			res[b].redraw       = rd;
			res[b].last_of_tick = !later;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q <= '0;
			sel_q  <= 1'b0;
		end else if (en) begin
			page_q <= page_d;
			sel_q  <= sel_d;
		end
	end

	`BRMN_ASSERT_IMPL(a_page_range, clk, arst_n, 1'b1, page_q <= PAGE_W'(PAGE_COUNT - 1))

endmodule

// ===== src/brmn_outq.sv =====
`include "button_repeat_menu_navigator_macros.svh"

module brmn_outq
	import brmn_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  logic [BUTTON_COUNT-1:0] fire,
	input  res_t res [BUTTON_COUNT],
	input  logic pop,
	output logic full,
	output logic nonempty,
	output res_t head
);

	res_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wptr_q, rptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic [QCNT_W-1:0] push_n;
	logic [QPTR_W-1:0] rank [BUTTON_COUNT];
	logic              do_pop;

	always_comb begin
		logic [QPTR_W-1:0] r;
		r = '0;
		for (int b = 0; b < BUTTON_COUNT; b++) begin
			rank[b] = r;
			r = r + QPTR_W'(fire[b]);
		end
		push_n = push ? QCNT_W'($countones(fire)) : '0;
	end

	assign nonempty = (cnt_q != '0);
	assign do_pop   = pop && nonempty;
	// room for a full tick's worth of results
	assign full     = (cnt_q > QCNT_W'(QDEPTH - MAX_RESULTS));
	assign head     = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		for (int b = 0; b < BUTTON_COUNT; b++)
			if (push && fire[b])
				mem_q[wptr_q + rank[b]] <= res[b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			wptr_q <= wptr_q + push_n[QPTR_W-1:0];
			if (do_pop)
				rptr_q <= rptr_q + QPTR_W'(1);
			cnt_q <= cnt_q + push_n - QCNT_W'(do_pop);
		end
	end

	`BRMN_ASSERT_IMPL(a_no_overflow, clk, arst_n, 1'b1, cnt_q <= QCNT_W'(QDEPTH))
	`BRMN_ASSERT_NEXT(a_pop_count, clk, arst_n, do_pop && push_n == '0, cnt_q == $past(cnt_q) - QCNT_W'(1))

endmodule

// ===== src/button_repeat_menu_navigator.sv =====
// Button debounce with auto-repeat driving a page/selection menu. Each accepted
// item is one tick carrying the left, middle and right button levels; three
// lanes update the per-button counters in the same cycle and a merge stage
// applies the resulting press and hold events, in button order, to the page
// and selection state. The zero to three results of a tick go into a
// four-entry output queue and leave one per cycle, in order, while out_stall
// is low, with last_of_tick set on the final one. A tick is accepted in any
// cycle in which the queue holds at most one result, so ticks can follow back
// to back; the single output port sets the sustained rate at one result per
// cycle. Configuration writes take effect on the next tick.
`include "button_repeat_menu_navigator_macros.svh"

module button_repeat_menu_navigator
	import brmn_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        left_down,
	input  logic        middle_down,
	input  logic        right_down,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  button_id,
	output logic        event_kind,
	output logic [1:0]  action,
	output logic [1:0]  page,
	output logic        selected,
	output logic        redraw,
	output logic        last_of_tick
);

	cfg_t      cfg_q;
	logic      accept;
	logic      q_full;
	logic [BUTTON_COUNT-1:0] downs;
	logic [BUTTON_COUNT-1:0] fire;
	lane_evt_t evt [BUTTON_COUNT];
	res_t      res [BUTTON_COUNT];
	res_t      head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks <= RST_DEBOUNCE;
			cfg_q.first_hold     <= RST_FIRST_HOLD;
			cfg_q.repeat_gap     <= RST_REPEAT_GAP;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEBOUNCE:   cfg_q.debounce_ticks <= cfg_data;
				REG_FIRST_HOLD: cfg_q.first_hold     <= cfg_data;
				REG_REPEAT_GAP: cfg_q.repeat_gap     <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign downs    = {right_down, middle_down, left_down};

	for (genvar b = 0; b < BUTTON_COUNT; b++) begin : g_lane
		brmn_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (accept),
			.down   (downs[b]),
			.cfg    (cfg_q),
			.evt    (evt[b])
		);
		assign fire[b] = evt[b].fire;
	end

	brmn_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (accept),
		.evt    (evt),
		.res    (res)
	);

	brmn_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (accept),
		.fire     (fire),
		.res      (res),
		.pop      (!out_stall),
		.full     (q_full),
		.nonempty (out_valid),
		.head     (head)
	);

	assign button_id    = head.button_id;
	assign event_kind   = head.event_kind;
	assign action       = head.action;
	assign page         = head.page;
	assign selected     = head.selected;
	assign redraw       = head.redraw;
	assign last_of_tick = head.last_of_tick;

	`BRMN_ASSERT_IMPL(a_hold_unsel, clk, arst_n, out_valid && event_kind == EV_HOLD && !selected, action == ACT_NONE && !redraw)

endmodule
